// ===== rtl/b32d_pkg.sv =====
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants of the base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

  // Width of the per-string output byte counter
  localparam int COUNT_WIDTH = 16;
  // Width used for limit arithmetic (covers the 16-bit limit register)
  localparam int LIMIT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HEX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT    = 1'd1;
  localparam logic [15:0] OUT_LIMIT_RST = 16'hFFFF;

  // Special characters
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  // Job queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Group geometry: 8 characters of 5 bits give 5 bytes
  localparam int GROUP_BITS = 40;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_OVF  = 2'd3
  } kind_t;

  // One unit of work for the back end: n_data bytes from the top of bits,
  // then an end result if has_end is set
  typedef struct packed {
    logic [GROUP_BITS-1:0] bits;
    logic [2:0]            n_data;
    logic                  has_end;
    kind_t                 end_kind;
  } job_t;

endpackage

// ===== rtl/b32d_ifs.sv =====
// ----------------------------------------------------------------------------
// b32d_ifs
// Stream channels of the base32 decoder: characters in, results out.
// ----------------------------------------------------------------------------
interface b32d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface b32d_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ===== rtl/base32_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base32_stream_decoder
// Base32 (standard or hex alphabet) string decoder, one character per
// transaction in, one result per transaction out.
// ----------------------------------------------------------------------------
// The decoder accepts one character per cycle whenever its four-entry job
// queue has room; ready drops only while that queue is full. Each character
// is classified in the cycle it is accepted; a completed group, an end of
// string or an error becomes one job, and the serializer behind the queue
// delivers that job's results one per cycle while the output is ready. A
// result passes through the queue entry and then the working job register
// before it reaches the output. Sustained input rate is one character per
// cycle for data while the output keeps up (five results per eight
// characters); runs of end characters that each produce results are limited
// to the serializer's one result per cycle. Configuration writes take effect
// on the next cycle and are meant for when no transaction is in flight.
module base32_stream_decoder import b32d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  b32d_in_if.sink               din,
  b32d_out_if.source            dout,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        alphabet_hex;
  logic [15:0] out_limit;

  logic push, queue_full, q_valid, pop;
  job_t push_job, q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_hex <= 1'b0;
      out_limit    <= OUT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ALPHABET_HEX: alphabet_hex <= cfg_data[0];
        REG_OUT_LIMIT:    out_limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  b32d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .din          (din),
    .alphabet_hex (alphabet_hex),
    .out_limit    (out_limit),
    .queue_full   (queue_full),
    .push         (push),
    .job          (push_job)
  );

  b32d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  b32d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .dout    (dout)
  );

endmodule

// ===== rtl/b32d_front.sv =====
// ----------------------------------------------------------------------------
// b32d_front
// Character front end: maps characters, collects groups, tracks the byte
// budget and hands complete jobs to the queue.
// ----------------------------------------------------------------------------
module b32d_front import b32d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  b32d_in_if.sink              din,
  input  logic                 alphabet_hex,
  input  logic [15:0]          out_limit,
  input  logic                 queue_full,
  output logic                 push,
  output job_t                 job
);

  localparam logic [LIMIT_W-1:0] COUNT_MAX =
    LIMIT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  // {valid, value}
  function automatic logic [5:0] map_char(input logic [7:0] c, input logic hex);
    logic [7:0] d;
    d = 8'd0;
    if (hex) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        return {1'b1, d[4:0]};
      end
      if (c >= 8'h41 && c <= 8'h56) begin
        d = c - 8'h41 + 8'd10;
        return {1'b1, d[4:0]};
      end
    end else begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41;
        return {1'b1, d[4:0]};
      end
      if (c >= 8'h32 && c <= 8'h37) begin
        d = c - 8'h32 + 8'd26;
        return {1'b1, d[4:0]};
      end
    end
    return 6'd0;
  endfunction

  logic [4:0]             grp [8];
  logic [2:0]             fill, fill_next;
  logic [COUNT_WIDTH-1:0] bytes_out, bytes_out_next;
  logic                   draining, draining_next;

  logic                   fire;
  logic [5:0]             mc;
  logic                   is_nul, is_end, grp_we;
  logic [GROUP_BITS-1:0]  pack_old, pack_new;
  logic [2:0]             end_cnt, cnt, n_fit;
  logic [LIMIT_W-1:0]     limit, bo_ext, avail;
  logic                   ovf;

  assign din.ready = !queue_full;

  // Classification, byte budget and job build
  always_comb begin
    fire   = din.valid && din.ready;
    mc     = map_char(din.ch, alphabet_hex);
    is_nul = (din.ch == CHAR_NUL);
    is_end = is_nul || (din.ch == CHAR_PAD);

    for (int i = 0; i < 8; i++) begin
      pack_old[GROUP_BITS-1-5*i -: 5] = grp[i];
      pack_new[GROUP_BITS-1-5*i -: 5] = (3'(i) == fill) ? mc[4:0] : grp[i];
    end

    end_cnt = 3'((6'(fill) * 6'd5) >> 3);
    cnt     = is_end ? end_cnt : 3'd5;

    limit  = (LIMIT_W'(out_limit) > COUNT_MAX) ? COUNT_MAX : LIMIT_W'(out_limit);
    bo_ext = LIMIT_W'(bytes_out);
    avail  = (limit > bo_ext) ? (limit - bo_ext) : '0;
    ovf    = (avail < LIMIT_W'(cnt));
    n_fit  = ovf ? avail[2:0] : cnt;

    fill_next      = fill;
    bytes_out_next = bytes_out;
    draining_next  = draining;
    push           = 1'b0;
    grp_we         = 1'b0;
    job.bits       = pack_old;
    job.n_data     = 3'd0;
    job.has_end    = 1'b0;
    job.end_kind   = KIND_OK;

    if (fire) begin
      if (draining) begin
        if (is_nul) begin
          draining_next  = 1'b0;
          fill_next      = 3'd0;
          bytes_out_next = '0;
        end
      end else if (is_end) begin
        // Partial group, then end result (or an overflow result in place of it)
        push           = 1'b1;
        job.n_data     = n_fit;
        job.has_end    = 1'b1;
        job.end_kind   = ovf ? KIND_OVF : KIND_OK;
        fill_next      = 3'd0;
        bytes_out_next = '0;
        draining_next  = !is_nul;
      end else if (!mc[5]) begin
        push          = 1'b1;
        job.has_end   = 1'b1;
        job.end_kind  = KIND_BAD;
        fill_next     = 3'd0;
        draining_next = 1'b1;
      end else begin
        grp_we = 1'b1;
        if (fill == 3'd7) begin
          // Group complete: five bytes, cut short by the budget
          push           = 1'b1;
          job.bits       = pack_new;
          job.n_data     = n_fit;
          job.has_end    = ovf;
          job.end_kind   = KIND_OVF;
          fill_next      = 3'd0;
          bytes_out_next = bytes_out + COUNT_WIDTH'(n_fit);
          draining_next  = ovf;
        end else begin
          fill_next = fill + 3'd1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= 3'd0;
      bytes_out <= '0;
      draining  <= 1'b0;
    end else begin
      fill      <= fill_next;
      bytes_out <= bytes_out_next;
      draining  <= draining_next;
    end
  end

  // Group character store
  always_ff @(posedge clk) begin
    if (grp_we) grp[fill] <= mc[4:0];
  end

  // Every job yields at least one result
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (job.n_data != 3'd0 || job.has_end))
    else $error("empty job pushed");

  // Budget never exceeded by the counter
  a_budget: assert property (@(posedge clk) disable iff (rst)
    (push && !job.has_end) |-> (LIMIT_W'(job.n_data) <= avail))
    else $error("job exceeds byte budget");

endmodule

// ===== rtl/b32d_queue.sv =====
// ----------------------------------------------------------------------------
// b32d_queue
// Small job FIFO that decouples the character front end from the result
// serializer.
// ----------------------------------------------------------------------------
module b32d_queue import b32d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head
);

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("job queue underrun");

endmodule

// ===== rtl/b32d_back.sv =====
// ----------------------------------------------------------------------------
// b32d_back
// Result serializer: turns one job into its results, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module b32d_back import b32d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_head,
  output logic pop,
  b32d_out_if.source dout
);

  job_t       wjob;
  logic       wvalid;
  logic [2:0] idx;

  logic [2:0] total;
  logic       is_data, is_last, out_fire, done;
  logic [7:0] sel;

  // Current result from the working job
  always_comb begin
    total   = wjob.n_data + 3'(wjob.has_end);
    is_data = (idx < wjob.n_data);
    is_last = ((idx + 3'd1) == total);
    case (idx)
      3'd0:    sel = wjob.bits[39:32];
      3'd1:    sel = wjob.bits[31:24];
      3'd2:    sel = wjob.bits[23:16];
      3'd3:    sel = wjob.bits[15:8];
      3'd4:    sel = wjob.bits[7:0];
      default: sel = 8'd0;
    endcase
    out_fire = dout.valid && dout.ready;
    done     = out_fire && is_last;
    pop      = (!wvalid || done) && q_valid;
  end

  assign dout.valid    = wvalid;
  assign dout.kind     = is_data ? KIND_DATA : wjob.end_kind;
  assign dout.out_byte = is_data ? sel : 8'd0;
  assign dout.last     = is_last;

  // Working job control
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
      idx    <= 3'd0;
    end else if (pop) begin
      wvalid <= 1'b1;
      idx    <= 3'd0;
    end else if (done) begin
      wvalid <= 1'b0;
    end else if (out_fire) begin
      idx <= idx + 3'd1;
    end
  end

  // Working job payload
  always_ff @(posedge clk) begin
    if (pop) wjob <= q_head;
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    wvalid |-> (idx < total))
    else $error("result index past end of job");

endmodule
